/* hw/rtl/pbsd_pkg.sv */
// ----------------------------------------------------------------------------
// pbsd_pkg
// Shared constants, codes and types of the palette block stream decoder.
// ----------------------------------------------------------------------------
package pbsd_pkg;

  localparam int MAX_BLOCKS  = 4096;
  localparam int BLK_AW      = 12;
  localparam int CNT_W       = 13;
  localparam int CACHE_AW    = 8;
  localparam int RING_SEL_W  = 2;
  localparam int CACHE_MAW   = RING_SEL_W + CACHE_AW;

  // header code nibbles
  localparam logic [3:0] K_SKIP_S   = 4'd0;
  localparam logic [3:0] K_SKIP_L   = 4'd1;
  localparam logic [3:0] K_REP_S    = 4'd2;
  localparam logic [3:0] K_REP_L    = 4'd3;
  localparam logic [3:0] K_SOLID_S  = 4'd4;
  localparam logic [3:0] K_SOLID_L  = 4'd5;
  localparam logic [3:0] K_SEP_S    = 4'd6;
  localparam logic [3:0] K_SEP_L    = 4'd7;
  localparam logic [3:0] K_PAL2_IN  = 4'd8;
  localparam logic [3:0] K_PAL2_C   = 4'd9;
  localparam logic [3:0] K_PAL4_IN  = 4'd10;
  localparam logic [3:0] K_PAL4_C   = 4'd11;
  localparam logic [3:0] K_PAL8_IN  = 4'd12;
  localparam logic [3:0] K_PAL8_C   = 4'd13;
  localparam logic [3:0] K_RAW_S    = 4'd14;
  localparam logic [3:0] K_RAW_L    = 4'd15;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SEP  = 2'd1;
  localparam logic [1:0] ST_CLIP = 2'd2;

  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_LENGTH   = 6'b000010,
    PH_COLOR    = 6'b000100,
    PH_PALETTE  = 6'b001000,
    PH_PALINDEX = 6'b010000,
    PH_PIXELS   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic                we;
    logic [BLK_AW-1:0]   waddr;
    logic [127:0]        wdata;
    logic [BLK_AW-1:0]   raddr;
  } store_req_t;

  typedef struct packed {
    logic                 we;
    logic [CACHE_MAW-1:0] addr;
    logic [63:0]          wdata;
  } cache_req_t;

endpackage

/* hw/rtl/palette_block_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// palette_block_stream_decoder_core
// Parses the compressed byte stream and writes decoded 4x4 blocks.
// ----------------------------------------------------------------------------
// Steps: a byte is accepted (S_IDLE), then executed (S_EXEC); a cached
// palette index adds a cache read (S_CRD), a repeat a store read (S_RDWAIT);
// a run adds block store writes (S_WRITE), one row per cycle; the result is
// then loaded (S_EMIT), waiting on m_tready. No byte is accepted until the
// last one is done. Reset: rst clears control state and starts a zeroing
// pass over the block store with no byte accepted; block_count is 4096.
module palette_block_stream_decoder_core (
  input  logic         clk,
  input  logic         rst,
  // config write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [12:0]  cfg_data,     // block_count
  // byte stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,      // data_byte
  input  logic         s_tlast,      // last_byte
  // results out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,      // block_index[11:0], run_length[24:12],
                                     // pixels_low[88:25], pixels_high[152:89]
  output logic [1:0]   m_tuser       // status
);

  localparam int CW = pbsd_pkg::CNT_W;
  localparam int AW = pbsd_pkg::BLK_AW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_RDWAIT = 6'b000100,
    S_CRD    = 6'b001000,
    S_WRITE  = 6'b010000,
    S_EMIT   = 6'b100000
  } ctl_t;

  ctl_t             ctl, ctl_next;
  pbsd_pkg::phase_t phase, phase_next;
  logic [3:0]       code_kind, code_kind_next;
  logic [CW-1:0]    blocks_left, blocks_left_next;
  logic [4:0]       byte_counter, byte_counter_next;
  logic [127:0]     gather, gather_next;
  logic [63:0]      cur_pal, cur_pal_next;
  logic [CW-1:0]    next_block, next_block_next;
  logic [8:0]       heads [3];
  logic [8:0]       heads_next [3];
  logic [CW-1:0]    block_count;
  logic [7:0]       in_byte;
  logic             in_last;

  logic [CW-1:0]    em_start, em_start_next;
  logic [CW-1:0]    em_len, em_len_next;
  logic [1:0]       em_status, em_status_next;
  logic [63:0]      em_lo, em_lo_next, em_hi, em_hi_next;
  logic             rep_zero, rep_zero_next;
  logic [AW-1:0]    wr_addr;
  logic [CW-1:0]    wr_left;

  pbsd_pkg::store_req_t st_req;
  pbsd_pkg::cache_req_t ca_req;
  logic [127:0]     st_rdata;
  logic [63:0]      ca_rdata;
  logic             clr_busy;

  pbsd_store u_store (.clk(clk), .rst(rst), .req(st_req), .rdata(st_rdata),
                      .busy(clr_busy));
  pbsd_cache u_cache (.clk(clk), .req(ca_req), .rdata(ca_rdata));

  assign cfg_ready = 1'b1;
  assign s_tready  = (ctl == S_IDLE) && !clr_busy;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= CW'(pbsd_pkg::MAX_BLOCKS);
    end else if (cfg_valid) begin
      block_count <= cfg_data;
    end
  end

  // frame limit
  logic [CW-1:0] lim;
  assign lim = (block_count < CW'(pbsd_pkg::MAX_BLOCKS)) ? block_count
                                                         : CW'(pbsd_pkg::MAX_BLOCKS);

  // ring select and mask of the current palette code
  function automatic logic [1:0] ring_sel(input logic [3:0] k);
    logic [3:0] d;
    d = k - pbsd_pkg::K_PAL2_IN;
    return d[2:1];
  endfunction

  function automatic logic [63:0] ring_mask(input logic [1:0] s, input logic [63:0] v);
    case (s)
      2'd0:    return {48'h0, v[15:0]};
      2'd1:    return {32'h0, v[31:0]};
      default: return v;
    endcase
  endfunction

  // clip a run against the frame limit
  logic [CW-1:0] emit_len, ec_n, ec_avail, ec_nb;
  logic          ec_in;
  logic [CW:0]   ec_sum;
  always_comb begin
    ec_in    = next_block < lim;
    ec_avail = lim - next_block;
    ec_sum   = {1'b0, next_block} + {1'b0, emit_len};
    ec_n     = ec_in ? ((emit_len < ec_avail) ? emit_len : ec_avail) : '0;
    if (next_block > lim) begin
      ec_nb = next_block;
    end else if (ec_in && (ec_avail > emit_len)) begin
      ec_nb = ec_sum[CW-1:0];
    end else begin
      ec_nb = lim;
    end
  end

  // pixel byte gathering and palette expansion
  logic [1:0]   cur_sel;
  logic [4:0]   bc_inc, need;
  logic [127:0] g_upd;
  logic [63:0]  pal_lo, pal_hi;
  logic [2:0]   pidx;
  logic         is_raw;
  assign cur_sel = ring_sel(code_kind);
  assign is_raw  = code_kind >= pbsd_pkg::K_RAW_S;
  assign bc_inc  = byte_counter + 5'd1;
  always_comb begin
    need = is_raw ? 5'd16 : {2'b0, cur_sel + 2'd1, 1'b0};
    if (is_raw) begin
      g_upd = gather | ({120'h0, in_byte} << {byte_counter[3:0], 3'b000});
    end else begin
      g_upd = {64'h0, gather[55:0], in_byte};
    end
    pal_lo = '0;
    pal_hi = '0;
    for (int j = 0; j < 16; j++) begin
      case (cur_sel)
        2'd0:    pidx = {2'b0, g_upd[15-j]};
        2'd1:    pidx = {1'b0, g_upd[2*(15-j) +: 2]};
        default: pidx = g_upd[3*(15-j) +: 3];
      endcase
      if (j < 8) begin
        pal_lo[8*j +: 8] = cur_pal[{pidx, 3'b000} +: 8];
      end else begin
        pal_hi[8*(j-8) +: 8] = cur_pal[{pidx, 3'b000} +: 8];
      end
    end
  end

  // execute one byte
  logic [3:0]    kind_s;
  logic [CW-1:0] bl_s;
  logic          do_start, is_long;
  logic [8:0]    new_head;
  logic [CW:0]   skip_sum;
  always_comb begin
    ctl_next          = ctl;
    phase_next        = phase;
    code_kind_next    = code_kind;
    blocks_left_next  = blocks_left;
    byte_counter_next = byte_counter;
    gather_next       = gather;
    cur_pal_next      = cur_pal;
    next_block_next   = next_block;
    heads_next        = heads;
    em_start_next     = em_start;
    em_len_next       = em_len;
    em_status_next    = em_status;
    em_lo_next        = em_lo;
    em_hi_next        = em_hi;
    rep_zero_next     = rep_zero;
    emit_len          = blocks_left;
    ca_req            = '{we: 1'b0, addr: {cur_sel, in_byte}, wdata: '0};
    st_req.we         = (ctl == S_WRITE);
    st_req.waddr      = wr_addr;
    st_req.wdata      = {em_hi, em_lo};
    st_req.raddr      = AW'(next_block - 1'b1);

    is_long  = in_byte[7:4] inside {pbsd_pkg::K_SKIP_L, pbsd_pkg::K_REP_L,
                                    pbsd_pkg::K_SOLID_L, pbsd_pkg::K_SEP_L,
                                    pbsd_pkg::K_RAW_L};
    kind_s   = (phase == pbsd_pkg::PH_HEADER) ? in_byte[7:4] : code_kind;
    bl_s     = (phase == pbsd_pkg::PH_HEADER) ? CW'({1'b0, in_byte[3:0]}) + 1'b1
                                              : (blocks_left | CW'(in_byte)) + 1'b1;
    do_start = 1'b0;
    new_head = heads[cur_sel] + 9'd1;
    if (new_head[8]) new_head = '0;
    skip_sum = {1'b0, next_block} + {1'b0, bl_s};

    case (ctl)
      S_IDLE: begin
        if (s_tvalid && s_tready) ctl_next = S_EXEC;
      end
      S_EXEC: begin
        ctl_next = S_IDLE;
        case (phase)
          pbsd_pkg::PH_HEADER: begin
            code_kind_next = in_byte[7:4];
            if (is_long) begin
              blocks_left_next = {1'b0, in_byte[3:0], 8'h00};
              phase_next       = pbsd_pkg::PH_LENGTH;
            end else begin
              do_start = 1'b1;
            end
          end
          pbsd_pkg::PH_LENGTH: do_start = 1'b1;
          pbsd_pkg::PH_COLOR: begin
            phase_next     = pbsd_pkg::PH_HEADER;
            emit_len       = blocks_left;
            em_lo_next     = {8{in_byte}};
            em_hi_next     = {8{in_byte}};
            em_start_next  = next_block;
            em_len_next    = ec_n;
            em_status_next = (ec_n < emit_len) ? pbsd_pkg::ST_CLIP : pbsd_pkg::ST_OK;
            next_block_next = ec_nb;
            ctl_next       = (ec_n != '0) ? S_WRITE : S_EMIT;
          end
          pbsd_pkg::PH_PALETTE: begin
            cur_pal_next = cur_pal | ({56'h0, in_byte} << {byte_counter[2:0], 3'b000});
            byte_counter_next = bc_inc;
            if (bc_inc >= {2'b0, cur_sel + 2'd1, 1'b0} + {2'b0, cur_sel == 2'd2, 2'b0}
                          - {3'b0, cur_sel == 2'd2, 1'b0}) begin
              heads_next[cur_sel] = new_head;
              ca_req.we     = 1'b1;
              ca_req.addr   = {cur_sel, new_head[7:0]};
              ca_req.wdata  = ring_mask(cur_sel, cur_pal_next);
              phase_next    = pbsd_pkg::PH_PIXELS;
              byte_counter_next = '0;
              gather_next   = '0;
            end
          end
          pbsd_pkg::PH_PALINDEX: begin
            if (!in_last) ctl_next = S_CRD;
          end
          pbsd_pkg::PH_PIXELS: begin
            gather_next       = g_upd;
            byte_counter_next = bc_inc;
            if (bc_inc >= need) begin
              emit_len       = CW'(1);
              em_lo_next     = is_raw ? g_upd[63:0] : pal_lo;
              em_hi_next     = is_raw ? g_upd[127:64] : pal_hi;
              em_start_next  = next_block;
              em_len_next    = ec_n;
              em_status_next = (ec_n < emit_len) ? pbsd_pkg::ST_CLIP : pbsd_pkg::ST_OK;
              next_block_next = ec_nb;
              ctl_next       = (ec_n != '0) ? S_WRITE : S_EMIT;
              byte_counter_next = '0;
              gather_next    = '0;
              blocks_left_next = blocks_left - 1'b1;
              if (blocks_left_next == '0) phase_next = pbsd_pkg::PH_HEADER;
            end
          end
          default: phase_next = pbsd_pkg::PH_HEADER;
        endcase

        // start a code once its length is known
        if (do_start) begin
          blocks_left_next = bl_s;
          case (kind_s)
            pbsd_pkg::K_SKIP_S, pbsd_pkg::K_SKIP_L: begin
              phase_next = pbsd_pkg::PH_HEADER;
              if (next_block < lim) begin
                next_block_next = ((lim - next_block) > bl_s) ? skip_sum[CW-1:0] : lim;
              end
            end
            pbsd_pkg::K_REP_S, pbsd_pkg::K_REP_L: begin
              phase_next     = pbsd_pkg::PH_HEADER;
              emit_len       = bl_s;
              rep_zero_next  = (next_block == '0);
              em_start_next  = next_block;
              em_len_next    = ec_n;
              em_status_next = (ec_n < emit_len) ? pbsd_pkg::ST_CLIP : pbsd_pkg::ST_OK;
              next_block_next = ec_nb;
              ctl_next       = S_RDWAIT;
            end
            pbsd_pkg::K_SOLID_S, pbsd_pkg::K_SOLID_L: phase_next = pbsd_pkg::PH_COLOR;
            pbsd_pkg::K_SEP_S, pbsd_pkg::K_SEP_L: begin
              phase_next     = pbsd_pkg::PH_HEADER;
              em_start_next  = next_block;
              em_len_next    = '0;
              em_status_next = pbsd_pkg::ST_SEP;
              em_lo_next     = '0;
              em_hi_next     = '0;
              ctl_next       = S_EMIT;
            end
            pbsd_pkg::K_PAL2_IN, pbsd_pkg::K_PAL4_IN, pbsd_pkg::K_PAL8_IN: begin
              phase_next        = pbsd_pkg::PH_PALETTE;
              byte_counter_next = '0;
              cur_pal_next      = '0;
            end
            pbsd_pkg::K_PAL2_C, pbsd_pkg::K_PAL4_C, pbsd_pkg::K_PAL8_C:
              phase_next = pbsd_pkg::PH_PALINDEX;
            default: begin
              phase_next        = pbsd_pkg::PH_PIXELS;
              byte_counter_next = '0;
              gather_next       = '0;
            end
          endcase
        end

        // drop the frame state after its final byte
        if (in_last) begin
          phase_next        = pbsd_pkg::PH_HEADER;
          code_kind_next    = '0;
          blocks_left_next  = '0;
          byte_counter_next = '0;
          gather_next       = '0;
          cur_pal_next      = '0;
          next_block_next   = '0;
          for (int i = 0; i < 3; i++) heads_next[i] = '1;
        end
      end
      S_RDWAIT: begin
        em_lo_next = rep_zero ? '0 : st_rdata[63:0];
        em_hi_next = rep_zero ? '0 : st_rdata[127:64];
        ctl_next   = (em_len != '0) ? S_WRITE : S_EMIT;
      end
      S_CRD: begin
        cur_pal_next      = ring_mask(cur_sel, ca_rdata);
        phase_next        = pbsd_pkg::PH_PIXELS;
        byte_counter_next = '0;
        gather_next       = '0;
        ctl_next          = S_IDLE;
      end
      S_WRITE: begin
        if (wr_left == CW'(1)) ctl_next = S_EMIT;
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) ctl_next = S_IDLE;
      end
      default: ctl_next = S_IDLE;
    endcase
  end

  // control and parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl          <= S_IDLE;
      phase        <= pbsd_pkg::PH_HEADER;
      code_kind    <= '0;
      blocks_left  <= '0;
      byte_counter <= '0;
      gather       <= '0;
      cur_pal      <= '0;
      next_block   <= '0;
      for (int i = 0; i < 3; i++) heads[i] <= '1;
    end else begin
      ctl          <= ctl_next;
      phase        <= phase_next;
      code_kind    <= code_kind_next;
      blocks_left  <= blocks_left_next;
      byte_counter <= byte_counter_next;
      gather       <= gather_next;
      cur_pal      <= cur_pal_next;
      next_block   <= next_block_next;
      heads        <= heads_next;
    end
  end

  // hold the accepted beat and the pending result
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
    em_start  <= em_start_next;
    em_len    <= em_len_next;
    em_status <= em_status_next;
    em_lo     <= em_lo_next;
    em_hi     <= em_hi_next;
    rep_zero  <= rep_zero_next;
    if (ctl == S_WRITE) begin
      wr_addr <= wr_addr + 1'b1;
      wr_left <= wr_left - 1'b1;
    end else begin
      wr_addr <= em_start_next[AW-1:0];
      wr_left <= em_len_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl == S_EMIT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl == S_EMIT && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'h0,
                  (em_len == '0) ? 64'h0 : em_hi,
                  (em_len == '0) ? 64'h0 : em_lo,
                  em_len, em_start[AW-1:0]};
      m_tuser <= em_status;
    end
  end

endmodule

/* hw/rtl/pbsd_store.sv */
// ----------------------------------------------------------------------------
// pbsd_store
// Block store: one 128-bit row per block, registered read, zeroing pass
// after reset.
// ----------------------------------------------------------------------------
module pbsd_store (
  input  logic                clk,
  input  logic                rst,
  input  pbsd_pkg::store_req_t req,
  output logic [127:0]        rdata,
  output logic                busy
);

  logic [127:0] mem [0:pbsd_pkg::MAX_BLOCKS-1];
  logic [pbsd_pkg::BLK_AW:0] clr_cnt;

  assign busy = !clr_cnt[pbsd_pkg::BLK_AW];

  // advance the zeroing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // write port: zeros while clearing, else the request
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt[pbsd_pkg::BLK_AW-1:0]] <= '0;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

/* hw/rtl/pbsd_cache.sv */
// ----------------------------------------------------------------------------
// pbsd_cache
// Palette ring cache: three rings of 256 entries in one memory, selected
// by the top address bits.
// ----------------------------------------------------------------------------
module pbsd_cache (
  input  logic                clk,
  input  pbsd_pkg::cache_req_t req,
  output logic [63:0]         rdata
);

  logic [63:0] mem [0:(1 << pbsd_pkg::CACHE_MAW)-1];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule
